### hdl/tcc_pkg.sv
// Shared types, constants and cadence rules for the tone cadence classifier.
package tcc_pkg;

  localparam int Tones         = 5;
  localparam int SegPerToneDef = 16;
  localparam int SegW          = 17;
  localparam int DurW          = 16;
  localparam int ScoreW        = 16;
  localparam int BonusW        = 15;

  localparam logic [DurW-1:0]   MinSegMs      = 16'd10;
  localparam logic [ScoreW-1:0] PromoteFloor  = 16'd13107;
  localparam logic [15:0]       OneQ16        = 16'hFFFF;
  localparam logic [6:0]        RunMax        = 7'd127;

  localparam logic [3:0] CodeRinging  = 4'd3;
  localparam logic [3:0] CodeRingback = 4'd4;
  localparam logic [3:0] CodeBusy     = 4'd6;
  localparam logic [3:0] CodeReorder  = 4'd7;
  localparam logic [3:0] CodeHangup   = 4'd8;

  localparam logic [1:0] RegHistory = 2'd0;
  localparam logic [1:0] RegEnter   = 2'd1;
  localparam logic [1:0] RegHold    = 2'd2;

  typedef struct packed {
    logic [DurW-1:0]   on_min;
    logic [DurW-1:0]   on_max;
    logic [DurW-1:0]   off_min;
    logic [DurW-1:0]   off_max;
    logic [BonusW-1:0] bonus;
    logic [3:0]        code;
  } tcc_rule_t;

  typedef tcc_rule_t tcc_rules_t [Tones];

  // busy, reorder, hangup, ringback, ringing
  localparam tcc_rules_t Rules = '{
    '{16'd350,  16'd750,  16'd350,  16'd750,  15'd19661, CodeBusy},
    '{16'd120,  16'd360,  16'd120,  16'd360,  15'd22938, CodeReorder},
    '{16'd120,  16'd1200, 16'd120,  16'd2000, 15'd26214, CodeHangup},
    '{16'd1200, 16'd2600, 16'd2500, 16'd5500, 15'd22938, CodeRingback},
    '{16'd1000, 16'd3000, 16'd2500, 16'd5500, 15'd26214, CodeRinging}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_SUM,
    ST_TRIM,
    ST_SCORE,
    ST_DIV,
    ST_PROMOTE,
    ST_FINISH
  } tcc_state_t;

  typedef struct packed {
    tcc_state_t phase;
    logic       first;
  } tcc_ctl_t;

  typedef struct packed {
    logic              done;
    logic [ScoreW-1:0] score;
  } tcc_stat_t;

endpackage

### hdl/tcc_seg_cell.sv
// One segment cell of a tracker chain: takes its neighbor's segment on shift.
module tcc_seg_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [tcc_pkg::SegW-1:0]  seg_in,
  output logic [tcc_pkg::SegW-1:0]  seg_out,
  output logic                      level,
  output logic [tcc_pkg::DurW-1:0]  dur
);
  import tcc_pkg::*;

  logic [SegW-1:0] seg_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      seg_r <= seg_in;
    end
  end

  assign seg_out = seg_r;
  assign level   = seg_r[SegW-1];
  assign dur     = seg_r[DurW-1:0];

endmodule

### hdl/tcc_tone.sv
// Tone tracker: segment chain, history trim, pair match scan and score divider.
module tcc_tone #(
  parameter int SegPerTone = tcc_pkg::SegPerToneDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcc_pkg::tcc_ctl_t   ctl,
  input  tcc_pkg::tcc_rule_t  rule,
  input  logic                act,
  input  logic [31:0]         now_ms,
  input  logic [14:0]         limit,
  output tcc_pkg::tcc_stat_t  stat
);
  import tcc_pkg::*;

  localparam int CW   = $clog2(SegPerTone + 1);
  localparam int IW   = $clog2(SegPerTone);
  localparam int TW   = DurW + CW;
  localparam int NumW = BonusW + IW;
  localparam int DcW  = $clog2(NumW + 1);

  logic [SegW-1:0] seg_in  [SegPerTone];
  logic [SegW-1:0] seg_out [SegPerTone];
  logic            seg_lvl [SegPerTone];
  logic [DurW-1:0] seg_dur [SegPerTone];

  logic            started_r, level_r, edged_r;
  logic [31:0]     edge_r;
  logic [CW-1:0]   count_r;
  logic [IW-1:0]   pos_r;
  logic [TW-1:0]   total_r;
  logic [SegW-1:0] prev_r;
  logic            prev_v_r;
  logic [IW-1:0]   pairs_r, match_r;
  logic [NumW-1:0] num_r, quo_r;
  logic [IW-1:0]   rem_r;
  logic [DcW-1:0]  dcnt_r;
  logic            done_r;

  logic [31:0]     dur_raw;
  logic [DurW-1:0] dur_sat;
  logic            edge_ev, keep, scan, shift, valid;
  logic            e_lvl;
  logic [DurW-1:0] e_dur, p_dur;
  logic [IW:0]     trial;

  assign dur_raw = now_ms - edge_r;
  assign dur_sat = (dur_raw > 32'h0000FFFF) ? OneQ16 : dur_raw[DurW-1:0];
  assign edge_ev = started_r && (level_r != act);
  assign keep    = edge_ev && (dur_sat >= MinSegMs);
  assign scan    = (ctl.phase == ST_SUM) || (ctl.phase == ST_TRIM) ||
                   (ctl.phase == ST_SCORE);
  assign shift   = scan || ((ctl.phase == ST_TRACK) && keep);

  // Rotate during scans; on a new segment the oldest falls off the far end.
  assign seg_in[0] = (ctl.phase == ST_TRACK) ? {level_r, dur_sat} : seg_out[SegPerTone-1];

  for (genvar i = 0; i < SegPerTone; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign seg_in[i] = seg_out[i-1];
    end
    tcc_seg_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .seg_in  (seg_in[i]),
      .seg_out (seg_out[i]),
      .level   (seg_lvl[i]),
      .dur     (seg_dur[i])
    );
  end

  // Newest segment sits in cell 0; the far cell presents oldest-first.
  assign e_lvl = seg_lvl[SegPerTone-1];
  assign e_dur = seg_dur[SegPerTone-1];
  assign p_dur = prev_r[DurW-1:0];
  assign valid = CW'(pos_r) < count_r;
  assign trial = {rem_r, num_r[NumW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      level_r   <= 1'b0;
      edge_r    <= '0;
      edged_r   <= 1'b0;
      count_r   <= '0;
      pos_r     <= '0;
      total_r   <= '0;
      prev_v_r  <= 1'b0;
      pairs_r   <= '0;
      match_r   <= '0;
      dcnt_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      case (ctl.phase)
        ST_TRACK: begin
          pos_r    <= IW'(SegPerTone - 1);
          total_r  <= '0;
          prev_v_r <= 1'b0;
          pairs_r  <= '0;
          match_r  <= '0;
          done_r   <= 1'b0;
          edged_r  <= edge_ev;
          if (!started_r) begin
            started_r <= 1'b1;
            level_r   <= act;
            edge_r    <= now_ms;
          end else if (edge_ev) begin
            level_r <= act;
            edge_r  <= now_ms;
            if (keep && count_r != CW'(SegPerTone)) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        ST_SUM, ST_TRIM, ST_SCORE: begin
          pos_r <= (pos_r == '0) ? IW'(SegPerTone - 1) : pos_r - 1'b1;
          if (ctl.phase == ST_SUM) begin
            if (valid) begin
              total_r <= total_r + TW'(e_dur);
            end
          end else if (ctl.phase == ST_TRIM) begin
            if (valid && edged_r && total_r > TW'(limit)) begin
              total_r <= total_r - TW'(e_dur);
              count_r <= count_r - 1'b1;
            end
          end else if (valid) begin
            prev_v_r <= 1'b1;
            if (prev_v_r && prev_r[SegW-1] && !e_lvl) begin
              pairs_r <= pairs_r + 1'b1;
              if (p_dur >= rule.on_min && p_dur <= rule.on_max &&
                  e_dur >= rule.off_min && e_dur <= rule.off_max) begin
                match_r <= match_r + 1'b1;
              end
            end
          end
        end
        ST_DIV: begin
          if (ctl.first) begin
            dcnt_r <= DcW'(NumW);
          end else if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 1'b1;
            if (dcnt_r == DcW'(1)) begin
              done_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.phase == ST_SCORE && valid) begin
      prev_r <= {e_lvl, e_dur};
    end
    if (ctl.phase == ST_DIV) begin
      if (ctl.first) begin
        num_r <= NumW'(rule.bonus) * NumW'(match_r);
        rem_r <= '0;
        quo_r <= '0;
      end else if (dcnt_r != '0) begin
        num_r <= num_r << 1;
        if (trial >= {1'b0, pairs_r}) begin
          rem_r <= IW'(trial - {1'b0, pairs_r});
          quo_r <= {quo_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= trial[IW-1:0];
          quo_r <= {quo_r[NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.score = (pairs_r == '0) ? '0 : ScoreW'(quo_r[BonusW-1:0]);

endmodule

### hdl/tone_cadence_classifier.sv
// Top level: request capture, sequencer, cadence promotion and state debounce.
//
// One request per analysis window enters on in_* and yields exactly one result
// on out_*. in_tready is high only while the sequencer is idle; a request then
// runs through a tracking step, three passes that each rotate every tracker's
// segment chain once around (sum, history trim, pair scan), bit-serial score
// division, a promotion step and an output step.
// All five trackers run in lockstep.
// The result sits in an output register: a request can be accepted while the
// previous result still waits, and the finish state stalls only while the output
// register is full and out_tready is low.
// cfg_* writes are always taken (cfg_ready is tied high); writes should be
// made while the block is idle. Index 0 history limit, 1 enter windows,
// 2 hold windows; other indexes are ignored.
// rst_n (synchronous) clears trackers, segment counts, debounce state and
// restores register defaults 8000 / 3 / 3.
module tone_cadence_classifier #(
  parameter int SegPerTone = tcc_pkg::SegPerToneDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [35:32] raw_state, [51:36] raw_confidence,
  // [56:52] active_mask, [57] ring_indicator, [63:58] zero
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] promoted_state, [19:4] out_confidence, [23:20] stable_state,
  // [24] stable_changed, [31:25] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import tcc_pkg::*;

  localparam int IW = $clog2(SegPerTone);

  tcc_state_t state_r, state_nxt;
  logic [IW-1:0] step_r, step_nxt;

  logic [31:0] now_r;
  logic [3:0]  raw_r;
  logic [15:0] conf_r;
  logic [4:0]  mask_r;
  logic        ri_r;

  logic [14:0] limit_r;
  logic [5:0]  enter_r;
  logic [6:0]  hold_r;

  logic [3:0]  cand_r, settled_r, pstate_r;
  logic [6:0]  run_r;
  logic [15:0] pconf_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  tcc_ctl_t  ctl;
  tcc_stat_t stat [Tones];
  logic [Tones-1:0] done_v;
  logic [ScoreW-1:0] sc [Tones];

  logic       step_last, accept, finish;
  logic [3:0] pstate_nxt;
  logic [15:0] pconf_nxt;
  logic [16:0] add_sum;
  logic [ScoreW-1:0] add_b;
  logic        add_en;
  logic [6:0]  run_nxt, needed;
  logic [3:0]  cand_nxt, settled_nxt;
  logic        changed;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign step_last = (step_r == IW'(SegPerTone - 1));
  assign finish    = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_TRACK;
      ST_TRACK:   state_nxt = ST_SUM;
      ST_SUM:     if (step_last) state_nxt = ST_TRIM;
      ST_TRIM:    if (step_last) state_nxt = ST_SCORE;
      ST_SCORE:   if (step_last) state_nxt = ST_DIV;
      ST_DIV:     if (&done_v) state_nxt = ST_PROMOTE;
      ST_PROMOTE: state_nxt = ST_FINISH;
      ST_FINISH:  if (finish) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if ((state_r == ST_SUM || state_r == ST_TRIM || state_r == ST_SCORE) && !step_last) begin
      step_nxt = step_r + 1'b1;
    end else if (state_r == ST_DIV) begin
      step_nxt = IW'(1);
    end
  end

  always_comb begin
    ctl.phase = state_r;
    ctl.first = (step_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r  <= in_tdata[31:0];
      raw_r  <= in_tdata[35:32];
      conf_r <= in_tdata[51:36];
      mask_r <= in_tdata[56:52];
      ri_r   <= in_tdata[57];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 15'd8000;
      enter_r <= 6'd3;
      hold_r  <= 7'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegHistory: limit_r <= cfg_data;
        RegEnter:   enter_r <= cfg_data[5:0];
        RegHold:    hold_r  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar t = 0; t < Tones; t++) begin : g_tone
    tcc_tone #(.SegPerTone(SegPerTone)) u_tone (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .rule   (Rules[t]),
      .act    (mask_r[t] || (raw_r == Rules[t].code)),
      .now_ms (now_r),
      .limit  (limit_r),
      .stat   (stat[t])
    );
    assign done_v[t] = stat[t].done;
    assign sc[t]     = stat[t].score;
  end

  // Promotion of the disconnect family, otherwise the raw state's own bonus.
  always_comb begin
    pstate_nxt = raw_r;
    add_b      = '0;
    if (raw_r == CodeHangup) begin
      if (sc[0] > PromoteFloor && sc[0] >= sc[1] && sc[0] >= sc[2]) begin
        pstate_nxt = CodeBusy;
        add_b      = sc[0];
      end else if (sc[1] > PromoteFloor && sc[1] >= sc[0] && sc[1] >= sc[2]) begin
        pstate_nxt = CodeReorder;
        add_b      = sc[1];
      end else begin
        add_b = sc[2];
      end
    end else begin
      for (int t = 0; t < Tones; t++) begin
        if (Rules[t].code == raw_r) begin
          add_b = sc[t];
        end
      end
    end
    add_en    = (add_b != '0);
    add_sum   = {1'b0, conf_r} + {1'b0, add_b};
    pconf_nxt = !add_en ? conf_r : (add_sum[16] ? OneQ16 : add_sum[15:0]);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PROMOTE) begin
      pstate_r <= pstate_nxt;
      pconf_r  <= pconf_nxt;
    end
  end

  always_comb begin
    cand_nxt    = pstate_r;
    run_nxt     = run_r;
    if (pstate_r != cand_r) begin
      run_nxt = 7'd1;
    end else if (run_r < RunMax) begin
      run_nxt = run_r + 1'b1;
    end
    needed      = (pstate_r == settled_r) ? hold_r : {1'b0, enter_r};
    settled_nxt = settled_r;
    changed     = 1'b0;
    if (((pstate_r == CodeRinging) && ri_r) || run_nxt >= needed) begin
      settled_nxt = pstate_r;
      changed     = (settled_r != pstate_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= '0;
      run_r       <= '0;
      settled_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (finish) begin
      cand_r      <= cand_nxt;
      run_r       <= run_nxt;
      settled_r   <= settled_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {7'd0, changed, settled_nxt, pconf_r, pstate_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_accept_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_TRACK)
    else $error("request accepted without starting a track cycle");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_changed_settled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[23:20] == out_tdata[3:0])
    else $error("stable change does not match promoted state");
`endif

endmodule

### dv/tone_cadence_classifier_test.sv
// Testbench for the tone cadence classifier: random and directed windows, scoreboard check.
`timescale 1ns / 1ps

module tone_cadence_classifier_test;
  import tcc_pkg::*;

  typedef struct packed {
    logic [3:0]  promoted;
    logic [15:0] conf;
    logic [3:0]  settled;
    logic        changed;
  } verdict_t;

  class cadence_scoreboard;
    int unsigned hist_limit = 8000;
    int unsigned enter_win = 3;
    int unsigned hold_win = 3;
    bit started [Tones];
    bit level [Tones];
    logic [31:0] last_edge [Tones];
    logic [16:0] segs [Tones][$];
    logic [3:0] cand_code;
    int unsigned cand_run;
    logic [3:0] settled;
    verdict_t pending [$];
    int errors;

    function void clear();
      for (int t = 0; t < Tones; t++) begin
        started[t] = 0;
        level[t] = 0;
        last_edge[t] = 0;
        segs[t].delete();
      end
      cand_code = 0;
      cand_run = 0;
      settled = 0;
      hist_limit = 8000;
      enter_win = 3;
      hold_win = 3;
    endfunction

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      if (idx == RegHistory) hist_limit = val;
      else if (idx == RegEnter) enter_win = val[5:0];
      else if (idx == RegHold) hold_win = val[6:0];
    endfunction

    function void follow_tone(int t, bit act, logic [31:0] now);
      logic [31:0] dur;
      int unsigned total;
      if (!started[t]) begin
        started[t] = 1;
        level[t] = act;
        last_edge[t] = now;
        return;
      end
      if (level[t] == act) return;
      dur = now - last_edge[t];
      if (dur > 32'hFFFF) dur = 32'hFFFF;
      if (dur >= MinSegMs) begin
        if (segs[t].size() >= SegPerToneDef) segs[t].delete(0);
        segs[t].insert(segs[t].size(), {level[t], dur[15:0]});
      end
      level[t] = act;
      last_edge[t] = now;
      total = 0;
      foreach (segs[t][i]) total += segs[t][i][15:0];
      while (total > hist_limit && segs[t].size() > 0) begin
        total -= segs[t][0][15:0];
        segs[t].delete(0);
      end
    endfunction

    function int unsigned fit_score(int t);
      int unsigned pairs, hits, on_ms, off_ms;
      pairs = 0;
      hits = 0;
      for (int i = 0; i + 1 < segs[t].size(); i++) begin
        if (!segs[t][i][16] || segs[t][i+1][16]) continue;
        pairs++;
        on_ms = segs[t][i][15:0];
        off_ms = segs[t][i+1][15:0];
        if (on_ms >= Rules[t].on_min && on_ms <= Rules[t].on_max &&
            off_ms >= Rules[t].off_min && off_ms <= Rules[t].off_max) hits++;
      end
      if (pairs == 0) return 0;
      return (Rules[t].bonus * hits) / pairs;
    endfunction

    function void note_window(logic [63:0] d);
      logic [31:0] now;
      logic [3:0] code;
      int unsigned conf, sb, sr, sh, need, cad;
      logic [4:0] mask;
      bit ri, chg;
      verdict_t v;
      now = d[31:0];
      code = d[35:32];
      conf = d[51:36];
      mask = d[56:52];
      ri = d[57];
      chg = 0;
      for (int t = 0; t < Tones; t++) follow_tone(t, mask[t] || code == Rules[t].code, now);
      if (code == CodeHangup) begin
        sb = fit_score(0);
        sr = fit_score(1);
        sh = fit_score(2);
        if (sb > PromoteFloor && sb >= sr && sb >= sh) begin
          code = CodeBusy;
          conf += sb;
        end else if (sr > PromoteFloor && sr >= sb && sr >= sh) begin
          code = CodeReorder;
          conf += sr;
        end else conf += sh;
      end else begin
        cad = 0;
        for (int t = 0; t < Tones; t++) if (Rules[t].code == code) cad = fit_score(t);
        conf += cad;
      end
      if (conf > 65535) conf = 65535;
      if (code != cand_code) begin
        cand_code = code;
        cand_run = 1;
      end else if (cand_run < RunMax) cand_run++;
      need = (code == settled) ? hold_win : enter_win;
      if ((code == CodeRinging && ri) || cand_run >= need) begin
        chg = settled != code;
        settled = code;
      end
      v.promoted = code;
      v.conf = conf[15:0];
      v.settled = settled;
      v.changed = chg;
      pending.insert(pending.size(), v);
    endfunction

    function void check_result(logic [31:0] d);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (d[3:0] != e.promoted) begin
        $error("promoted_state expected %0d actual %0d", e.promoted, d[3:0]);
        errors++;
      end
      if (d[19:4] != e.conf) begin
        $error("out_confidence expected %0d actual %0d", e.conf, d[19:4]);
        errors++;
      end
      if (d[23:20] != e.settled) begin
        $error("stable_state expected %0d actual %0d", e.settled, d[23:20]);
        errors++;
      end
      if (d[24] != e.changed) begin
        $error("stable_changed expected %0d actual %0d", e.changed, d[24]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  cadence_scoreboard board = new();
  bit calm = 0;
  logic [31:0] clock_ms;
  int unsigned cycles = 0;

  tone_cadence_classifier i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tone_cadence_classifier_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_tready <= 0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  // valid stays up after a request; the next request or a drain takes it over
  task automatic send_window(logic [31:0] now, logic [3:0] code, logic [15:0] conf,
                             logic [4:0] mask, bit ri);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tdata <= {6'd0, ri, mask, conf, code, now};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_window({6'd0, ri, mask, conf, code, now});
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // one cadence-shaped burst on one tone, in the tone's window or near it
  task automatic play_cadence(int t, int cyc);
    int unsigned on_ms, off_ms;
    logic [3:0] code;
    for (int k = 0; k < cyc; k++) begin
      on_ms = $urandom_range(Rules[t].on_min - 20, Rules[t].on_max + 20);
      off_ms = $urandom_range(Rules[t].off_min - 20, Rules[t].off_max + 20);
      code = ($urandom_range(0, 2) == 0) ? Rules[t].code : CodeHangup;
      clock_ms += on_ms;
      send_window(clock_ms, code, 16'($urandom), 5'd1 << t, 1'($urandom_range(0, 1)));
      clock_ms += off_ms;
      send_window(clock_ms, ($urandom_range(0, 1)) ? CodeHangup : 4'($urandom_range(0, 15)),
                  16'($urandom), 5'd0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned sel;
    board.clear();
    repeat (6) @(negedge clk);
    rst_n <= 1;
    clock_ms = 32'hFFFF_F000;
    // directed: extremes, every code, wrap, long gaps
    send_window(32'd0, 4'd0, 16'd0, 5'd0, 0);
    send_window(32'hFFFF_FFFF, 4'd15, 16'hFFFF, 5'h1F, 1);
    send_window(32'd5, 4'd8, 16'hFFFF, 5'd0, 1);
    for (int c = 0; c < 16; c++) send_window(32'd100 + c * 400, c[3:0], 16'hFFF0, 5'($urandom), 1);
    send_window(32'd200000, 4'd3, 16'd1, 5'h10, 1);
    send_window(32'd200003, 4'd3, 16'd1, 5'h00, 0);
    send_window(32'hFFFF_FFF0, 4'd6, 16'h8000, 5'h1F, 0);
    drain();
    write_reg(RegHistory, 15'd0);
    write_reg(RegEnter, 15'd0);
    write_reg(RegHold, 15'd0);
    clock_ms = 32'd1000;
    play_cadence(0, 4);
    drain();
    write_reg(RegHistory, 15'h7FFF);
    write_reg(RegEnter, 15'd63);
    write_reg(RegHold, 15'd127);
    for (int k = 0; k < 200; k++) send_window(clock_ms + k * 10, 4'd5, 16'($urandom), 5'd0, 0);
    clock_ms += 3000;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(RegHistory, 15'($urandom_range(1000, 30000)));
      write_reg(RegEnter, 15'($urandom_range(1, 50)));
      write_reg(RegHold, 15'($urandom_range(1, 100)));
      if (ph == 5) calm = 1;
      for (int k = 0; k < 80; k++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) play_cadence($urandom_range(0, Tones - 1), $urandom_range(1, 3));
        else begin
          clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400);
          send_window(clock_ms, 4'($urandom), 16'($urandom), 5'($urandom),
                      1'($urandom_range(0, 1)));
        end
      end
    end
    drain();
    if (board.errors == 0) $display("tone_cadence_classifier_test: PASS");
    else $display("tone_cadence_classifier_test: FAIL");
    $finish;
  end
endmodule
